// ===== hdl/ssf_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helper functions for the seven-segment frame encoder
// no dependencies

package ssf_pkg;

	// frame slots per value: enough for the widest display and for five digits plus a dash
	localparam int MAX_FRAMES  = 8;
	localparam int FRAME_IDX_W = 3;
	localparam int FRAME_CNT_W = 4;
	localparam int VALUE_W     = 16;

	// active-low segment codes, bit 7 is the decimal point
	localparam logic [7:0] SEG_DASH  = 8'hBF;
	localparam logic [7:0] SEG_BLANK = 8'hFF;

	typedef logic [3:0] bcd_t;

	// sign, range and magnitude of one request
	typedef struct packed {
		logic                neg;
		logic                oor;
		logic [VALUE_W-1:0]  mag;
	} ssf_class_t;

	// decimal digits of one request, least significant first
	typedef struct packed {
		logic                    neg;
		logic                    oor;
		logic [2:0]              nd;
		bcd_t [MAX_FRAMES-1:0]   dig;
	} ssf_dec_t;

	// power of ten, elaboration only
	function automatic longint pow10(input int n);
		longint p;
		p = 1;
		for (int i = 0; i < n; i++) begin
			p = p * 10;
		end
		return p;
	endfunction

	// digit to active-low segment pattern
	function automatic logic [7:0] seg_of_digit(input bcd_t d);
		logic [7:0] s;
		unique case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

	// one-hot select for frame slot k, positions past four have no select line
	function automatic logic [3:0] sel_of_index(input logic [FRAME_IDX_W-1:0] k);
		return k[2] ? 4'b0000 : (4'b0001 << k[1:0]);
	endfunction

	// quotient by ten for values below 100, exact through reciprocal 205 / 2^11
	function automatic bcd_t div10(input logic [6:0] x);
		logic [14:0] p;
		p = 15'(x) * 15'd205;
		return p[14:11];
	endfunction

endpackage

// ===== hdl/ssf_if.sv =====
`timescale 1ns / 1ps
// valid/ready channels for values in and display frames out
// depends on nothing

interface ssf_value_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface ssf_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] segments;
	logic [3:0] digit_select;
	logic       last;

	modport source (output valid, output segments, output digit_select, output last, input ready);
	modport sink   (input valid, input segments, input digit_select, input last, output ready);
endinterface

// ===== hdl/ssf_classify.sv =====
`timescale 1ns / 1ps
// stage 1: sign, display range check and magnitude
// depends on ssf_pkg and ssf_value_if

module ssf_classify #(
	parameter int DIGITS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	ssf_value_if.sink           item,
	output logic                dn_valid,
	input  logic                dn_ready,
	output ssf_pkg::ssf_class_t dn_data
);
	import ssf_pkg::*;

	localparam longint UPPER = pow10(DIGITS);
	localparam longint LOWER = -pow10(DIGITS - 1);
	localparam logic signed [31:0] UPPER_L = 32'(UPPER);
	localparam logic signed [31:0] LOWER_L = 32'(LOWER);

	logic               valid_s1;
	ssf_class_t         cls_s1;
	ssf_class_t         cls;
	logic signed [31:0] v;
	logic               en_s1;

	assign en_s1      = !valid_s1 || dn_ready;
	assign item.ready = en_s1;

	always_comb begin
		v       = $signed({{16{item.value[15]}}, item.value});
		cls.neg = item.value[15];
		cls.oor = (v <= LOWER_L) || (v >= UPPER_L);
		// -32768 negates to 0x8000, which is its magnitude as unsigned
		cls.mag = item.value[15] ? (~item.value + 16'd1) : item.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && item.valid) begin
			cls_s1 <= cls;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = cls_s1;
endmodule

// ===== hdl/ssf_decimal.sv =====
`timescale 1ns / 1ps
// stages 2 to 4: binary magnitude to five decimal digits by reciprocal multiplies
// depends on ssf_pkg

module ssf_decimal (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  ssf_pkg::ssf_class_t up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output ssf_pkg::ssf_dec_t   dn_data
);
	import ssf_pkg::*;

	// 83887 / 2^23 gives an exact quotient by 100 for every 16-bit value
	localparam logic [32:0] RECIP_100 = 33'd83887;

	logic valid_s2, valid_s3, valid_s4;
	logic en_s2, en_s3, en_s4;

	logic       neg_s2, oor_s2;
	logic [15:0] mag_s2;
	logic [9:0]  q100_s2;

	logic       neg_s3, oor_s3;
	logic [6:0] lo_s3, mid_s3;
	logic [2:0] top_s3;

	ssf_dec_t   dec_s4;

	logic [32:0] p2;
	logic [15:0] lo_w, pt;
	logic [2:0]  top;
	logic [9:0]  mid_w;
	bcd_t        d0, d1, d2, d3;
	logic [6:0]  t0, t2;
	ssf_dec_t    dec;

	assign en_s4    = !valid_s4 || dn_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign up_ready = en_s2;

	// stage 2: hundreds quotient
	assign p2 = 33'(up_data.mag) * RECIP_100;

	// stage 3: low pair, then split the quotient into thousands pair and ten-thousands
	always_comb begin
		lo_w  = mag_s2 - 16'(16'(q100_s2) * 16'd100);
		pt    = 16'(q100_s2) * 16'd41;
		top   = pt[14:12];
		mid_w = q100_s2 - 10'(10'(top) * 10'd100);
	end

	// stage 4: tens and units of each pair, digit count
	always_comb begin
		d1  = div10(lo_s3);
		t0  = lo_s3 - 7'(7'(d1) * 7'd10);
		d0  = t0[3:0];
		d3  = div10(mid_s3);
		t2  = mid_s3 - 7'(7'(d3) * 7'd10);
		d2  = t2[3:0];
		dec.neg = neg_s3;
		dec.oor = oor_s3;
		dec.dig = '0;
		dec.dig[0] = d0;
		dec.dig[1] = d1;
		dec.dig[2] = d2;
		dec.dig[3] = d3;
		dec.dig[4] = {1'b0, top_s3};
		// zero counts as one digit
		priority if (top_s3 != 3'd0) begin
			dec.nd = 3'd5;
		end else if (d3 != 4'd0) begin
			dec.nd = 3'd4;
		end else if (d2 != 4'd0) begin
			dec.nd = 3'd3;
		end else if (d1 != 4'd0) begin
			dec.nd = 3'd2;
		end else begin
			dec.nd = 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s2) begin
				valid_s2 <= up_valid;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && up_valid) begin
			neg_s2  <= up_data.neg;
			oor_s2  <= up_data.oor;
			mag_s2  <= up_data.mag;
			q100_s2 <= p2[32:23];
		end
		if (en_s3 && valid_s2) begin
			neg_s3 <= neg_s2;
			oor_s3 <= oor_s2;
			lo_s3  <= lo_w[6:0];
			mid_s3 <= mid_w[6:0];
			top_s3 <= top;
		end
		if (en_s4 && valid_s3) begin
			dec_s4 <= dec;
		end
	end

	assign dn_valid = valid_s4;
	assign dn_data  = dec_s4;
endmodule

// ===== hdl/ssf_serializer.sv =====
`timescale 1ns / 1ps
// frame sequencer: walks the digit slots of one value into the output register
// depends on ssf_pkg and ssf_frame_if

module ssf_serializer #(
	parameter int DIGITS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  ssf_pkg::ssf_dec_t up_data,
	ssf_frame_if.source       frame
);
	import ssf_pkg::*;

	localparam logic [FRAME_CNT_W-1:0] OOR_FRAMES = FRAME_CNT_W'(DIGITS);

	logic                   active_q;
	logic [FRAME_IDX_W-1:0] idx_q;
	logic [FRAME_CNT_W-1:0] nfr_q;
	logic                   oor_q;
	logic [2:0]             nd_q;
	bcd_t [MAX_FRAMES-1:0]  dig_q;

	logic                   out_valid_q;
	logic [7:0]             seg_q;
	logic [3:0]             sel_q;
	logic                   last_q;

	logic                   out_free, emit, last_k, take;
	logic [FRAME_CNT_W-1:0] nfr;
	logic [7:0]             seg;

	always_comb begin
		out_free = !out_valid_q || frame.ready;
		emit     = active_q && out_free;
		last_k   = (FRAME_CNT_W'(idx_q) + FRAME_CNT_W'(1)) == nfr_q;
		up_ready = !active_q || (emit && last_k);
		take     = up_valid && up_ready;
		nfr      = up_data.oor ? OOR_FRAMES
		                       : (FRAME_CNT_W'(up_data.nd) + FRAME_CNT_W'(up_data.neg));
		// digits up to the count, then the sign dash; all dashes for an out of range value
		if (oor_q || (idx_q >= nd_q)) begin
			seg = SEG_DASH;
		end else begin
			seg = seg_of_digit(dig_q[idx_q]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (emit && last_k) begin
				active_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + FRAME_IDX_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			nfr_q <= nfr;
			oor_q <= up_data.oor;
			nd_q  <= up_data.nd;
			dig_q <= up_data.dig;
		end
		if (emit) begin
			seg_q  <= seg;
			sel_q  <= sel_of_index(idx_q);
			last_q <= last_k;
		end
	end

	assign frame.valid        = out_valid_q;
	assign frame.segments     = seg_q;
	assign frame.digit_select = sel_q;
	assign frame.last         = last_q;
endmodule

// ===== hdl/signed_int_to_seven_segment_frames.sv =====
`timescale 1ns / 1ps
// top level of the signed integer to seven-segment frame encoder
// depends on ssf_pkg, ssf_if, ssf_classify, ssf_decimal, ssf_serializer

// Each accepted value becomes a run of display frames on the frame channel, one frame per
// cycle while the sink is ready: one frame for zero, DIGITS dash frames for a value out of
// display range, otherwise one frame per significant digit plus one dash for a negative,
// so a value yields 1 to DIGITS frames (at most six for wide displays). The frame sequencer
// that walks the digit slots of one value sets the frame count; the four stage front end
// (range check, hundreds split, pair split, tens split) takes a new value every cycle while
// not stalled, hiding its latency behind the frames of the previous value. The first frame
// passes the four front end stages and the sequencer output register. The last flag
// marks each value's final frame; decimal point is always off. No state survives between values.

module signed_int_to_seven_segment_frames #(
	parameter int DIGITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	ssf_value_if.sink   item,
	ssf_frame_if.source frame
);
	import ssf_pkg::*;

	// classify to decimal
	logic       cls_valid, cls_ready;
	ssf_class_t cls_data;

	// decimal to sequencer
	logic       dec_valid, dec_ready;
	ssf_dec_t   dec_data;

	// stage 1: sign, range and magnitude
	ssf_classify #(
		.DIGITS (DIGITS)
	) u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.dn_valid (cls_valid),
		.dn_ready (cls_ready),
		.dn_data  (cls_data)
	);

	// stages 2 to 4: decimal digits and digit count
	ssf_decimal u_decimal (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cls_valid),
		.up_ready (cls_ready),
		.up_data  (cls_data),
		.dn_valid (dec_valid),
		.dn_ready (dec_ready),
		.dn_data  (dec_data)
	);

	// frame sequencer with registered output
	ssf_serializer #(
		.DIGITS (DIGITS)
	) u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (dec_valid),
		.up_ready (dec_ready),
		.up_data  (dec_data),
		.frame    (frame)
	);
endmodule

// ===== hdl/ssf_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the seven-segment frame encoder, bound to the top level
// depends on ssf_pkg

module ssf_checker #(
	parameter int DIGITS = 4
) (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       frame_valid,
	input logic       frame_ready,
	input logic [7:0] frame_segments,
	input logic [3:0] frame_digit_select,
	input logic       frame_last
);
	import ssf_pkg::*;

	logic [3:0] pending_q;
	logic       in_acc, out_end;

	assign in_acc  = item_valid && item_ready;
	assign out_end = frame_valid && frame_ready && frame_last;

	// requests accepted whose last frame is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 4'(in_acc) - 4'(out_end);
		end
	end

	// a frame only shows while some request is in flight
	a_no_orphan_frame: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> pending_q != 4'd0)
		else $error("frame shown with no request in flight");

	// a taken frame that is not last, at positions one to three, is followed at once by the next position
	a_next_position: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && frame_ready && !frame_last &&
		 frame_digit_select != 4'b1000 && frame_digit_select != 4'b0000)
		|=> frame_valid && frame_digit_select == ($past(frame_digit_select) << 1))
		else $error("frame sequence skipped or stalled a position");

	// a dash at position one only comes from an out of range value
	a_dash_first: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && frame_segments == SEG_DASH && frame_digit_select == 4'b0001)
		|-> frame_last == (DIGITS == 1))
		else $error("dash at position one with wrong last flag");

	// stalled frame holds
	a_frame_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && !frame_ready) |=> frame_valid && $stable(frame_segments) &&
		$stable(frame_digit_select) && $stable(frame_last))
		else $error("stalled frame changed");
endmodule

bind signed_int_to_seven_segment_frames ssf_checker #(
	.DIGITS (DIGITS)
) u_ssf_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.item_valid         (item.valid),
	.item_ready         (item.ready),
	.frame_valid        (frame.valid),
	.frame_ready        (frame.ready),
	.frame_segments     (frame.segments),
	.frame_digit_select (frame.digit_select),
	.frame_last         (frame.last)
);
